>>> src/mrc_pkg.sv
// Shared types and constants for the mill run controller.
// No dependencies; used by mrc_period and mill_run_controller_core.
`default_nettype none

package mrc_pkg;

    typedef enum logic [1:0] {
        MODE_SPEED = 2'd0,
        MODE_TIME  = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_DONE  = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD_MIN  = 2'd0;
    localparam logic [1:0] CFG_PERIOD_MAX  = 2'd1;
    localparam logic [1:0] CFG_ADJUST_STEP = 2'd2;
    localparam logic [1:0] CFG_RAMP_STEP   = 2'd3;

    localparam logic [15:0] RST_PERIOD_MIN  = 16'd400;
    localparam logic [15:0] RST_PERIOD_MAX  = 16'd3000;
    localparam logic [9:0]  RST_ADJUST_STEP = 10'd100;
    localparam logic [9:0]  RST_RAMP_STEP   = 10'd10;

    localparam int          RST_PERIOD  = 2000;
    localparam int          RST_MINUTES = 30;
    localparam logic [12:0] SECONDS_CAP = 13'd7200;

    // encoder request toward the period unit
    typedef struct packed {
        logic adjust;  // clock edge seen while in speed menu
        logic down;    // shorten the period
    } t_enc_req;

endpackage

`default_nettype wire

>>> src/mrc_period.sv
// Target half-period adjust/clamp and current half-period ramp.
// Depends on mrc_pkg.
`default_nettype none

module mrc_period #(
    parameter int PERIOD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  mrc_pkg::t_enc_req           i_req,
    input  wire [15:0]                  i_period_min,
    input  wire [15:0]                  i_period_max,
    input  wire [9:0]                   i_adjust_step,
    input  wire [9:0]                   i_ramp_step,
    output logic [PERIOD_BITS-1:0]      o_target,
    output logic [PERIOD_BITS-1:0]      o_current
);

    localparam int WB = (PERIOD_BITS > 16) ? PERIOD_BITS : 16;
    localparam int W  = WB + 2;
    localparam logic [W-1:0] LIMIT = W'((64'd1 << PERIOD_BITS) - 64'd1);

    logic [PERIOD_BITS-1:0] r_target, r_current;
    logic [PERIOD_BITS-1:0] n_target, n_current;

    logic signed [W-1:0] sum_t;
    logic signed [W-1:0] pmin_s, pmax_s;
    logic [W-1:0]        clamp_t;
    logic [PERIOD_BITS-1:0] ramp_ext, diff;

    // target: step, raise to min, lower to max, hold within PERIOD_BITS
    always_comb begin
        pmin_s = $signed(W'(i_period_min));
        pmax_s = $signed(W'(i_period_max));
        if (i_req.down) begin
            sum_t = $signed(W'(r_target)) - $signed(W'(i_adjust_step));
        end else begin
            sum_t = $signed(W'(r_target)) + $signed(W'(i_adjust_step));
        end
        clamp_t = sum_t;
        if (sum_t < pmin_s) begin
            clamp_t = pmin_s;
        end
        if ($signed(clamp_t) > pmax_s) begin
            clamp_t = pmax_s;
        end
        if (clamp_t > LIMIT) begin
            clamp_t = LIMIT;
        end
        n_target = i_req.adjust ? PERIOD_BITS'(clamp_t) : r_target;
    end

    // ramp toward the new target without overshoot
    always_comb begin
        ramp_ext  = PERIOD_BITS'(i_ramp_step);
        diff      = '0;
        n_current = r_current;
        if (r_current < n_target) begin
            diff = n_target - r_current;
            n_current = (diff <= ramp_ext) ? n_target : r_current + ramp_ext;
        end else if (r_current > n_target) begin
            diff = r_current - n_target;
            n_current = (diff <= ramp_ext) ? n_target : r_current - ramp_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= PERIOD_BITS'(mrc_pkg::RST_PERIOD);
            r_current <= PERIOD_BITS'(mrc_pkg::RST_PERIOD);
        end else if (i_adv) begin
            r_target  <= n_target;
            r_current <= n_current;
        end
    end

    assign o_target  = n_target;
    assign o_current = n_current;

endmodule

`default_nettype wire

>>> src/mill_run_controller_core.sv
// Mill run controller top level: mode sequencing, run timer, config port.
// Depends on mrc_pkg and mrc_period.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one word per control-loop
//    pass carrying the encoder pin levels, a button-press event and a
//    one-second tick.
//  - Output channel (o_out_valid / i_out_ready): one result word per input
//    word: mode, motor enable, step pulse, current and target half-period,
//    run minutes, elapsed seconds and the run-done flag.
//  - Config channel (i_cfg_valid / o_cfg_ready): index 0 period_min,
//    1 period_max, 2 adjust_step, 3 ramp_step. Always ready; write only
//    while no word is in flight.
//  - Path: an accepted word goes through the input register, then one pass
//    of logic into the result register.
//  - Throughput: one word per cycle while results are taken; state update
//    is one pass of compares and adds between input and result registers.
//  - Stall: while a result waits, the input register still takes one more
//    word; after that o_in_ready drops until the result is taken.
//  - Reset: speed menu, target and current 2000 us, 30 minutes, count 0,
//    encoder clock idle high, motor off, config back to 400/3000/100/10.
`default_nettype none

module mill_run_controller_core #(
    parameter int PERIOD_BITS = 16,
    parameter int MAX_MINUTES = 120
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input words
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_enc_clk,
    input  wire         i_enc_dt,
    input  wire         i_button_press,
    input  wire         i_second_tick,
    // result words
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_mode,
    output logic        o_motor_enable,
    output logic        o_step_pulse,
    output logic [15:0] o_half_period,
    output logic [15:0] o_target_period,
    output logic [6:0]  o_target_minutes,
    output logic [12:0] o_elapsed_seconds,
    output logic        o_run_done,
    // config writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data
);

    // minutes register must hold both its reset value and the cap
    localparam int MIN_CAP = (MAX_MINUTES > mrc_pkg::RST_MINUTES) ?
                             MAX_MINUTES : mrc_pkg::RST_MINUTES;
    localparam int MW  = $clog2(MIN_CAP + 2);
    localparam int CW  = ((MW + 6) > 13) ? (MW + 6) : 13;
    localparam logic [MW:0] MAX_M = (MW+1)'(MAX_MINUTES);
    localparam logic [MW:0] ONE_M = (MW+1)'(1);

    // ---------------- config registers ----------------
    logic [15:0] r_period_min, r_period_max;
    logic [9:0]  r_adjust_step, r_ramp_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_min  <= mrc_pkg::RST_PERIOD_MIN;
            r_period_max  <= mrc_pkg::RST_PERIOD_MAX;
            r_adjust_step <= mrc_pkg::RST_ADJUST_STEP;
            r_ramp_step   <= mrc_pkg::RST_RAMP_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrc_pkg::CFG_PERIOD_MIN:  r_period_min  <= i_cfg_data;
                mrc_pkg::CFG_PERIOD_MAX:  r_period_max  <= i_cfg_data;
                mrc_pkg::CFG_ADJUST_STEP: r_adjust_step <= i_cfg_data[9:0];
                mrc_pkg::CFG_RAMP_STEP:   r_ramp_step   <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake / input register ----------------
    logic r_in_valid, r_out_valid;
    logic r_enc_clk, r_enc_dt, r_press, r_tick;
    logic adv, fire;

    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_enc_clk <= i_enc_clk;
            r_enc_dt  <= i_enc_dt;
            r_press   <= i_button_press;
            r_tick    <= i_second_tick;
        end
    end

    // ---------------- control state ----------------
    mrc_pkg::t_mode r_mode, n_mode, mode_a;
    logic [MW-1:0]  r_minutes, n_minutes;
    logic [12:0]    r_sec, n_sec;
    logic           r_prev_clk;
    logic           r_motor_on, n_motor_on;
    logic           pulse, done, run_expired;
    logic           enc_edge, enc_down;
    logic [MW:0]    m_step;
    logic [CW-1:0]  sec_limit;
    mrc_pkg::t_enc_req enc_req;
    logic [PERIOD_BITS-1:0] n_target, n_current;

    assign enc_edge = (r_enc_clk != r_prev_clk);
    assign enc_down = (r_enc_dt != r_enc_clk);

    // next state: button first, then run end on the updated count
    always_comb begin
        mode_a = r_mode;
        if (r_press) begin
            case (r_mode)
                mrc_pkg::MODE_SPEED: mode_a = mrc_pkg::MODE_TIME;
                mrc_pkg::MODE_TIME:  mode_a = mrc_pkg::MODE_RUN;
                mrc_pkg::MODE_RUN:   mode_a = mrc_pkg::MODE_SPEED;
                mrc_pkg::MODE_DONE:  mode_a = mrc_pkg::MODE_SPEED;
                default:             mode_a = mrc_pkg::MODE_SPEED;
            endcase
        end
        n_mode = mode_a;
        if (mode_a == mrc_pkg::MODE_RUN && run_expired) begin
            n_mode = mrc_pkg::MODE_DONE;
        end
    end

    // minutes adjust, active in time menu; encoder "down" adds a minute
    always_comb begin
        m_step    = {1'b0, r_minutes};
        n_minutes = r_minutes;
        if (enc_edge && mode_a == mrc_pkg::MODE_TIME) begin
            if (enc_down) begin
                m_step = {1'b0, r_minutes} + ONE_M;
            end else if ({1'b0, r_minutes} > ONE_M) begin
                m_step = {1'b0, r_minutes} - ONE_M;
            end else begin
                m_step = ONE_M;
            end
            if (m_step > MAX_M) begin
                m_step = MAX_M;
            end
            n_minutes = m_step[MW-1:0];
        end
    end

    assign enc_req.adjust = enc_edge && (mode_a == mrc_pkg::MODE_SPEED);
    assign enc_req.down   = enc_down;

    // outputs: motor, seconds, pulse, done
    always_comb begin
        n_motor_on = r_motor_on;
        n_sec      = r_sec;
        pulse      = 1'b0;
        done       = 1'b0;
        if (r_press) begin
            case (r_mode)
                mrc_pkg::MODE_TIME: begin
                    n_motor_on = 1'b1;
                    n_sec      = '0;
                end
                mrc_pkg::MODE_RUN:  n_motor_on = 1'b0;
                default: ;
            endcase
        end
        if (mode_a == mrc_pkg::MODE_RUN) begin
            pulse = 1'b1;
            if (r_tick && n_sec < mrc_pkg::SECONDS_CAP) begin
                n_sec = n_sec + 13'd1;
            end
        end
        sec_limit   = CW'(n_minutes) * CW'(60);
        run_expired = (CW'(n_sec) >= sec_limit);
        if (mode_a == mrc_pkg::MODE_RUN && run_expired) begin
            n_motor_on = 1'b0;
            done       = 1'b1;
        end
    end

    mrc_period #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_period (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (fire),
        .i_req         (enc_req),
        .i_period_min  (r_period_min),
        .i_period_max  (r_period_max),
        .i_adjust_step (r_adjust_step),
        .i_ramp_step   (r_ramp_step),
        .o_target      (n_target),
        .o_current     (n_current)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= mrc_pkg::MODE_SPEED;
            r_minutes  <= MW'(mrc_pkg::RST_MINUTES);
            r_sec      <= '0;
            r_prev_clk <= 1'b1;
            r_motor_on <= 1'b0;
        end else if (fire) begin
            r_mode     <= n_mode;
            r_minutes  <= n_minutes;
            r_sec      <= n_sec;
            r_prev_clk <= r_enc_clk;
            r_motor_on <= n_motor_on;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_mode            <= n_mode;
            o_motor_enable    <= n_motor_on;
            o_step_pulse      <= pulse;
            o_half_period     <= 16'(n_current);
            o_target_period   <= 16'(n_target);
            o_target_minutes  <= 7'(n_minutes);
            o_elapsed_seconds <= n_sec;
            o_run_done        <= done;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------- checks ----------------
    a_motor_tracks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_motor_on == (r_mode == mrc_pkg::MODE_RUN))
        else $error("motor enable out of step with run mode");

    a_done_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_done) |->
            (o_mode == mrc_pkg::MODE_DONE && !o_motor_enable && o_step_pulse))
        else $error("run end without finished mode");

    a_pulse_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_pulse) |->
            (o_mode == mrc_pkg::MODE_RUN || o_mode == mrc_pkg::MODE_DONE))
        else $error("step pulse outside a run");

    a_sec_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= mrc_pkg::SECONDS_CAP)
        else $error("second count past cap");

    a_no_update_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_mode) && $stable(r_sec) && $stable(r_minutes)))
        else $error("state moved without an accepted word");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for mill_run_controller_core: directed and random control-loop words,
// every result checked against an in-bench model of modes, encoder, ramp and timer.
// Depends on mrc_pkg and the controller RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int MAX_MIN     = 120;
    localparam int PERIOD_CAP  = 65535;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 4;     // extra wait once no result is outstanding

    // one expected result word per control-loop pass
    typedef struct packed {
        mrc_pkg::t_mode mode;
        logic        motor;
        logic        pulse;
        logic [15:0] half;
        logic [15:0] target;
        logic [6:0]  minutes;
        logic [12:0] secs;
        logic        done;
    } t_pass_result;

    // ------------------------------------------------------------------
    // clock, reset, DUT pins
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        enc_clk_pin = 1'b1;   // encoder clock idles high
    logic        enc_dt_pin = 1'b0;
    logic        press_pin = 1'b0;
    logic        tick_pin = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = mrc_pkg::CFG_PERIOD_MIN;
    logic [15:0] cfg_data = '0;

    wire         o_in_ready;
    wire         o_out_valid;
    wire  [1:0]  o_mode;
    wire         o_motor_enable;
    wire         o_step_pulse;
    wire  [15:0] o_half_period;
    wire  [15:0] o_target_period;
    wire  [6:0]  o_target_minutes;
    wire  [12:0] o_elapsed_seconds;
    wire         o_run_done;
    wire         o_cfg_ready;

    always #5 i_clk = ~i_clk;

    mill_run_controller_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_enc_clk         (enc_clk_pin),
        .i_enc_dt          (enc_dt_pin),
        .i_button_press    (press_pin),
        .i_second_tick     (tick_pin),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_mode            (o_mode),
        .o_motor_enable    (o_motor_enable),
        .o_step_pulse      (o_step_pulse),
        .o_half_period     (o_half_period),
        .o_target_period   (o_target_period),
        .o_target_minutes  (o_target_minutes),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_run_done        (o_run_done),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // controller model state and its copy of the config registers
    // ------------------------------------------------------------------
    mrc_pkg::t_mode ctl_mode;
    int    tgt_period;
    int    cur_period;
    int    run_min;
    int    sec_cnt;
    bit    enc_clk_last;
    bit    motor;
    int    cfg_pmin, cfg_pmax, cfg_adj, cfg_ramp;

    t_pass_result pass_results_q[$];   // expected words, oldest first

    // pacing and bookkeeping
    bit enc_lvl = 1'b1;        // clock level last sent on the encoder pin
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_left = 0;         // long receiver hold-off, counted in cycles
    int stall_left = 0;
    int words_sent = 0;
    int result_count = 0;
    int bad_results = 0;
    int cycle_count = 0;

    // One control-loop pass of the model: button, encoder, ramp, run timer.
    function automatic t_pass_result advance_controller(input bit clk, input bit dt,
                                                        input bit press, input bit tick);
        int           v;
        bit           pulse;
        bit           done;
        t_pass_result r;
        pulse = 1'b0;
        done  = 1'b0;

        if (press) begin
            case (ctl_mode)
                mrc_pkg::MODE_SPEED: ctl_mode = mrc_pkg::MODE_TIME;
                mrc_pkg::MODE_TIME: begin
                    ctl_mode = mrc_pkg::MODE_RUN;
                    sec_cnt  = 0;
                    motor    = 1'b1;
                end
                mrc_pkg::MODE_RUN: begin
                    ctl_mode = mrc_pkg::MODE_SPEED;
                    motor    = 1'b0;
                end
                default: ctl_mode = mrc_pkg::MODE_SPEED;
            endcase
        end

        // dt differing from clk means "down": shorter period, more minutes
        if (clk != enc_clk_last) begin
            if (ctl_mode == mrc_pkg::MODE_SPEED) begin
                v = tgt_period + ((dt != clk) ? -cfg_adj : cfg_adj);
                // floor first, then ceiling: an inverted window yields the max
                if (v < cfg_pmin) v = cfg_pmin;
                if (v > cfg_pmax) v = cfg_pmax;
                if (v < 0) v = 0;
                if (v > PERIOD_CAP) v = PERIOD_CAP;
                tgt_period = v;
            end else if (ctl_mode == mrc_pkg::MODE_TIME) begin
                v = run_min + ((dt != clk) ? 1 : -1);
                if (v < 1) v = 1;
                if (v > MAX_MIN) v = MAX_MIN;
                run_min = v;
            end
        end
        enc_clk_last = clk;

        // ramp without overshoot; zero step holds the current value
        if (cur_period < tgt_period) begin
            if (tgt_period - cur_period <= cfg_ramp) cur_period = tgt_period;
            else cur_period += cfg_ramp;
        end else if (cur_period > tgt_period) begin
            if (cur_period - tgt_period <= cfg_ramp) cur_period = tgt_period;
            else cur_period -= cfg_ramp;
        end

        if (ctl_mode == mrc_pkg::MODE_RUN) begin
            pulse = 1'b1;
            if (tick && sec_cnt < int'(mrc_pkg::SECONDS_CAP)) sec_cnt++;
            if (sec_cnt >= run_min * 60) begin
                ctl_mode = mrc_pkg::MODE_DONE;
                motor    = 1'b0;
                done     = 1'b1;
            end
        end

        r.mode    = ctl_mode;
        r.motor   = motor;
        r.pulse   = pulse;
        r.half    = cur_period[15:0];
        r.target  = tgt_period[15:0];
        r.minutes = run_min[6:0];
        r.secs    = sec_cnt[12:0];
        r.done    = done;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // sender: one input word, driven at the falling edge, held until taken
    // ------------------------------------------------------------------
    task automatic send_pass(input bit clk, input bit dt, input bit press, input bit tick);
        int gap;
        gap = send_idle_on ? draw_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid    = 1'b1;
        enc_clk_pin = clk;
        enc_dt_pin  = dt;
        press_pin   = press;
        tick_pin    = tick;
        do @(posedge i_clk); while (!o_in_ready);
        pass_results_q.push_back(advance_controller(clk, dt, press, tick));
        enc_lvl = clk;
        words_sent++;
    endtask

    // A pass with or without an encoder detent; without one, dt is random.
    task automatic pass_enc(input bit move, input bit down, input bit press, input bit tick);
        bit clk;
        bit dt;
        clk = move ? ~enc_lvl : enc_lvl;
        dt  = move ? (down ? ~clk : clk) : 1'($urandom_range(0, 1));
        send_pass(clk, dt, press, tick);
    endtask

    task automatic noise_pass();
        pass_enc($urandom_range(0, 99) < 35, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 99) < 8, 1'($urandom_range(0, 1)));
    endtask

    // Stop offering words and wait until every expected result is back.
    task automatic wait_drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pass_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_drain();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mrc_pkg::CFG_PERIOD_MIN:  cfg_pmin = int'(data);
            mrc_pkg::CFG_PERIOD_MAX:  cfg_pmax = int'(data);
            mrc_pkg::CFG_ADJUST_STEP: cfg_adj  = int'(data[9:0]);
            default:                  cfg_ramp = int'(data[9:0]);
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] pmin, input logic [15:0] pmax,
                                  input logic [15:0] adj, input logic [15:0] ramp);
        write_reg(mrc_pkg::CFG_PERIOD_MIN, pmin);
        write_reg(mrc_pkg::CFG_PERIOD_MAX, pmax);
        write_reg(mrc_pkg::CFG_ADJUST_STEP, adj);
        write_reg(mrc_pkg::CFG_RAMP_STEP, ramp);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // Walk the menus: detents both ways in each menu, start with a tick on
    // the same pass, encoder ignored while running, abort back to speed.
    task automatic test_menu_walk();
        pass_enc(0, 0, 0, 0);
        pass_enc(1, 1, 0, 0);
        pass_enc(1, 0, 0, 0);
        pass_enc(0, 0, 1, 0);
        pass_enc(1, 1, 0, 0);
        pass_enc(1, 0, 0, 1);
        pass_enc(0, 0, 1, 1);
        pass_enc(1, 1, 0, 1);
        pass_enc(0, 0, 1, 0);
        pass_enc(0, 1, 0, 1);
    endtask

    // Target clamps at both ends of 16 bits, inverted window, zero adjust,
    // zero ramp, and a ramp large enough to snap.
    task automatic test_period_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd10);
        pass_enc(1, 0, 0, 0);
        apply_settings(16'd5, 16'd5, 16'hFFFF, 16'd10);
        pass_enc(1, 0, 0, 0);
        apply_settings(16'd0, 16'hFFFF, 16'd1023, 16'd10);
        pass_enc(1, 1, 0, 0);
        apply_settings(16'd5000, 16'd1000, 16'd100, 16'd10);
        pass_enc(1, 0, 0, 0);
        apply_settings(mrc_pkg::RST_PERIOD_MIN, mrc_pkg::RST_PERIOD_MAX, 16'd0, 16'd0);
        pass_enc(1, 1, 0, 0);
        pass_enc(1, 0, 0, 0);
        apply_settings(mrc_pkg::RST_PERIOD_MIN, mrc_pkg::RST_PERIOD_MAX,
                       16'(mrc_pkg::RST_ADJUST_STEP), 16'd1023);
        pass_enc(0, 0, 0, 0);
        apply_settings(mrc_pkg::RST_PERIOD_MIN, mrc_pkg::RST_PERIOD_MAX,
                       16'(mrc_pkg::RST_ADJUST_STEP), 16'(mrc_pkg::RST_RAMP_STEP));
    endtask

    task automatic test_random_noise();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (300) noise_pass();
    endtask

    // Well-formed sessions: set speed, set minutes, start, tick until the
    // run ends (or a press aborts it), then now and then press out of finished.
    task automatic test_timed_runs();
        int first;
        int goal;
        int r;
        int in_run;
        first = words_sent;
        while (words_sent - first < 780) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            goal = (r < 70) ? 1 : (r < 90) ? 2 : MAX_MIN;

            while (ctl_mode != mrc_pkg::MODE_SPEED) pass_enc(0, 0, 1, 0);
            repeat ($urandom_range(0, 4)) pass_enc(1, 1'($urandom_range(0, 1)), 0, 0);
            pass_enc(0, 0, 1, 0);
            while (run_min != goal) pass_enc(1, run_min < goal, 0, 0);
            // push against the minutes clamp
            if (goal == 1) pass_enc(1, 0, 0, 0);
            if (goal == MAX_MIN) pass_enc(1, 1, 0, 0);
            pass_enc(0, 0, 1, 1'($urandom_range(0, 1)));

            in_run = 0;
            while (ctl_mode == mrc_pkg::MODE_RUN) begin
                // a max-length run would take 7200 ticks: abort it early
                pass_enc($urandom_range(0, 99) < 30, 1'($urandom_range(0, 1)),
                         (goal == MAX_MIN && in_run >= 40) || $urandom_range(0, 999) < 3,
                         $urandom_range(0, 99) < 75);
                in_run++;
            end
            if ($urandom_range(0, 1)) pass_enc(0, 0, 1, 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver holds off long while the sender keeps offering: the block
    // fills and drops o_in_ready. Then the sender waits for a full drain, and random traffic resumes.
    task automatic test_backpressure();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        wait_drain();
        @(posedge i_clk);
        hold_left = 150;
        repeat (40) noise_pass();
        wait_drain();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (160) noise_pass();
    endtask

    // One config setting, then detents mostly down and later mostly up.
    task automatic sweep_setting(input logic [15:0] pmin, input logic [15:0] pmax,
                                 input logic [15:0] adj, input logic [15:0] ramp);
        apply_settings(pmin, pmax, adj, ramp);
        for (int i = 0; i < 60; i++) begin
            pass_enc($urandom_range(0, 99) < 60,
                     (i < 30) ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 99) < 20),
                     $urandom_range(0, 99) < 4, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_config_sweep();
        sweep_setting(16'd1, 16'hFFFF, 16'd1000, 16'd1000);
        sweep_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFC00);  // upper bits dropped, ramp 0
        sweep_setting(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        sweep_setting(16'd5000, 16'd1000, 16'd0, 16'd1023);  // inverted window
        sweep_setting(mrc_pkg::RST_PERIOD_MIN, mrc_pkg::RST_PERIOD_MAX,
                      16'(mrc_pkg::RST_ADJUST_STEP), 16'(mrc_pkg::RST_RAMP_STEP));
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus the long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else begin
            out_ready = 1'b1;
            if (recv_idle_on) stall_left = draw_gap();
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_pass_result want;
        t_pass_result got;
        if (rst_n && o_out_valid && out_ready) begin
            result_count++;
            if (pass_results_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result word %0d arrived with none expected", result_count);
            end else begin
                want        = pass_results_q.pop_front();
                got.mode    = mrc_pkg::t_mode'(o_mode);
                got.motor   = o_motor_enable;
                got.pulse   = o_step_pulse;
                got.half    = o_half_period;
                got.target  = o_target_period;
                got.minutes = o_target_minutes;
                got.secs    = o_elapsed_seconds;
                got.done    = o_run_done;
                if (got !== want) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("mismatch on result word %0d (mode motor pulse half %s",
                                 result_count, "target min sec done)");
                        $display("  exp %0d %0b %0b %0d %0d %0d %0d %0b", want.mode,
                                 want.motor, want.pulse, want.half, want.target,
                                 want.minutes, want.secs, want.done);
                        $display("  got %0d %0b %0b %0d %0d %0d %0d %0b", got.mode,
                                 got.motor, got.pulse, got.half, got.target,
                                 got.minutes, got.secs, got.done);
                    end
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // model reset state matches the block's reset
        ctl_mode     = mrc_pkg::MODE_SPEED;
        tgt_period   = mrc_pkg::RST_PERIOD;
        cur_period   = mrc_pkg::RST_PERIOD;
        run_min      = mrc_pkg::RST_MINUTES;
        sec_cnt      = 0;
        enc_clk_last = 1'b1;
        motor        = 1'b0;
        cfg_pmin     = int'(mrc_pkg::RST_PERIOD_MIN);
        cfg_pmax     = int'(mrc_pkg::RST_PERIOD_MAX);
        cfg_adj      = int'(mrc_pkg::RST_ADJUST_STEP);
        cfg_ramp     = int'(mrc_pkg::RST_RAMP_STEP);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        test_menu_walk();
        test_period_extremes();
        test_random_noise();
        test_timed_runs();
        test_backpressure();
        test_config_sweep();

        wait_drain();
        if (bad_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
